### design/srlh_pkg.sv
package srlh_pkg;

    localparam int NUM_BUCKETS     = 8;
    localparam int MIN_CHUNK_BYTES = 4096;
    localparam int BKT_W           = $clog2(NUM_BUCKETS);

    localparam int BLOCKS_W = 16;
    localparam int BSIZE_W  = 13;
    localparam int PROD_W   = BLOCKS_W + BSIZE_W;
    localparam int SIZE_W   = 28;
    localparam int CNT_W    = 64;

    localparam int IN_DATA_W  = 200;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 512;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_CMD   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] DIR_READ  = 2'd1;
    localparam logic [1:0] DIR_WRITE = 2'd2;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_DEFER  = 1'b1;

    localparam int         STAT_READY_BIT = 8;
    localparam logic [3:0] CARD_STATE_PRG = 4'd7;

    typedef struct packed {
        logic [BKT_W-1:0]  bucket;
        logic [SIZE_W-1:0] size;
    } bucket_info_t;

    typedef struct packed {
        logic [SIZE_W-1:0] last_size;
        logic [CNT_W-1:0]  reads;
        logic [CNT_W-1:0]  writes;
        logic [CNT_W-1:0]  read_lat;
        logic [CNT_W-1:0]  write_lat;
    } entry_t;

    // first field in the highest bits
    typedef struct packed {
        logic [2:0]          bucket_select;
        logic [31:0]         status_word;
        logic                is_send_status;
        logic [CNT_W-1:0]    latency;
        logic [CNT_W-1:0]    cur_time;
        logic [BSIZE_W-1:0]  block_size;
        logic [BLOCKS_W-1:0] blocks;
        logic [1:0]          direction;
    } in_item_t;

    typedef struct packed {
        logic              write_pending;
        logic [SIZE_W-1:0] max_latency_chunk;
        logic [CNT_W-1:0]  max_latency;
        logic [CNT_W-1:0]  total_write_blocks;
        logic [CNT_W-1:0]  total_read_blocks;
        logic [CNT_W-1:0]  write_latency_sum;
        logic [CNT_W-1:0]  read_latency_sum;
        logic [CNT_W-1:0]  write_count;
        logic [CNT_W-1:0]  read_count;
        logic [SIZE_W-1:0] bucket_chunk_bytes;
        logic [2:0]        bucket_index;
    } out_item_t;

endpackage

### design/srlh_ram.sv
module srlh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/srlh_bucket.sv
module srlh_bucket (
    input  logic                           clk,
    input  logic                           load,
    input  logic [srlh_pkg::BLOCKS_W-1:0]  blocks,
    input  logic [srlh_pkg::BSIZE_W-1:0]   block_size,
    output srlh_pkg::bucket_info_t         info
);
    import srlh_pkg::*;

    localparam int HBP_W   = $clog2(PROD_W + 1);
    localparam int IDX_W   = HBP_W + 2;
    localparam int MIN_HBP = $clog2(MIN_CHUNK_BYTES + 1);

    logic [PROD_W-1:0]       product_reg;
    logic [HBP_W-1:0]        hbp;
    logic                    not_pow2;
    logic signed [IDX_W-1:0] idx;

    function automatic logic [HBP_W-1:0] high_bit_pos(input logic [PROD_W-1:0] v);
        logic [HBP_W-1:0] n;
        n = '0;
        for (int i = 0; i < PROD_W; i++)
        begin
            if (v[i])
            begin
                n = HBP_W'(i + 1);
            end
        end
        return n;
    endfunction

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= PROD_W'(blocks * block_size);
        end
    end

    always_comb
    begin
        hbp      = high_bit_pos(product_reg);
        not_pow2 = (product_reg != '0) && ((product_reg & (product_reg - 1'b1)) != '0);
        idx      = $signed(IDX_W'(hbp)) - $signed(IDX_W'(MIN_HBP))
                   + $signed(IDX_W'(not_pow2));
        if (idx[IDX_W-1])
        begin
            info.bucket = '0;
        end
        else if (idx > NUM_BUCKETS - 1)
        begin
            info.bucket = BKT_W'(NUM_BUCKETS - 1);
        end
        else
        begin
            info.bucket = BKT_W'(idx);
        end
        info.size = SIZE_W'(product_reg);
    end

endmodule

### design/storage_request_latency_histogram_top.sv
// A result is written to the output register in the update state, after the RAM read state.
// A new item is taken only in the idle state (idle, read, update), set by the read-modify-write
// of the bucket RAM; the update state holds while the previous result is not yet taken.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_n, asynchronous, active low) clears all counters, the pending write,
// the configuration registers and the per-bucket valid bits; the RAM itself is not swept.
module storage_request_latency_histogram_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srlh_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [srlh_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [srlh_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // direction, blocks, block_size, cur_time, latency, is_send_status,
    // status_word, bucket_select (from bit 0 up)
    input  logic [srlh_pkg::IN_DATA_W-1:0]    s_tdata,
    // op
    input  logic [srlh_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bucket_index, bucket_chunk_bytes, read_count, write_count, read_latency_sum,
    // write_latency_sum, total_read_blocks, total_write_blocks, max_latency,
    // max_latency_chunk, write_pending (from bit 0 up)
    output logic [srlh_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import srlh_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_MODIFY} state_t;

    state_t            state_reg;
    logic              enable_reg;
    logic              defer_reg;
    logic              cfg_we;

    logic [1:0]        op_reg;
    in_item_t          item_reg;
    in_item_t          item_in;
    bucket_info_t      info;

    logic [NUM_BUCKETS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]  rtot_reg, rtot_next;
    logic [CNT_W-1:0]  wtot_reg, wtot_next;
    logic [CNT_W-1:0]  peak_lat_reg, peak_lat_next;
    logic [SIZE_W-1:0] peak_size_reg, peak_size_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [BKT_W-1:0]  pend_bucket_reg, pend_bucket_next;
    logic [BLOCKS_W-1:0] pend_blocks_reg, pend_blocks_next;
    logic [CNT_W-1:0]  pend_start_reg, pend_start_next;
    logic [CNT_W-1:0]  busy_time_reg, busy_time_next;
    logic [CNT_W-1:0]  wlat_reg;

    logic [BKT_W-1:0]  sel_clamped;
    logic [BKT_W-1:0]  addr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t            entry_cur, entry_new;
    logic              wr_entry;
    logic              busy_poll;
    logic              finish;
    logic              m_valid_reg;
    out_item_t         out_reg, out_next;

    assign item_in  = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite;
    assign prdata   = paddr[2] ? APB_DATA_W'(defer_reg) : APB_DATA_W'(enable_reg);
    assign finish   = (state_reg == ST_MODIFY) && (!m_valid_reg || m_tready);

    srlh_bucket u_bucket (
        .clk        (clk),
        .load       (s_tvalid && s_tready),
        .blocks     (item_in.blocks),
        .block_size (item_in.block_size),
        .info       (info)
    );

    srlh_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (finish && wr_entry),
        .waddr (addr),
        .wdata (entry_new),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (32'(item_reg.bucket_select) > NUM_BUCKETS - 1)
        begin
            sel_clamped = BKT_W'(NUM_BUCKETS - 1);
        end
        else
        begin
            sel_clamped = BKT_W'(item_reg.bucket_select);
        end
        case (op_reg)
            OP_DATA: addr = info.bucket;
            OP_CMD:  addr = pend_bucket_reg;
            default: addr = sel_clamped;
        endcase
    end

    always_comb
    begin
        entry_cur = valid_reg[addr] ? entry_t'(ram_rdata) : '0;
        entry_new        = entry_cur;
        wr_entry         = 1'b0;
        valid_next       = valid_reg;
        rtot_next        = rtot_reg;
        wtot_next        = wtot_reg;
        peak_lat_next    = peak_lat_reg;
        peak_size_next   = peak_size_reg;
        pend_valid_next  = pend_valid_reg;
        pend_bucket_next = pend_bucket_reg;
        pend_blocks_next = pend_blocks_reg;
        pend_start_next  = pend_start_reg;
        busy_time_next   = busy_time_reg;
        busy_poll = item_reg.is_send_status &&
                    (!item_reg.status_word[STAT_READY_BIT] ||
                     item_reg.status_word[STAT_READY_BIT+4:STAT_READY_BIT+1] == CARD_STATE_PRG);

        case (op_reg)
            OP_DATA:
            begin
                if (enable_reg)
                begin
                    wr_entry = 1'b1;
                    entry_new.last_size = info.size;
                    if (item_reg.direction == DIR_WRITE)
                    begin
                        if (defer_reg)
                        begin
                            pend_valid_next  = 1'b1;
                            pend_bucket_next = info.bucket;
                            pend_blocks_next = item_reg.blocks;
                            pend_start_next  = item_reg.cur_time - item_reg.latency;
                        end
                        else
                        begin
                            entry_new.writes    = entry_cur.writes + 1'b1;
                            entry_new.write_lat = entry_cur.write_lat + item_reg.latency;
                            wtot_next = wtot_reg + CNT_W'(item_reg.blocks);
                        end
                    end
                    else if (item_reg.direction == DIR_READ)
                    begin
                        entry_new.reads    = entry_cur.reads + 1'b1;
                        entry_new.read_lat = entry_cur.read_lat + item_reg.latency;
                        rtot_next = rtot_reg + CNT_W'(item_reg.blocks);
                    end
                    if (peak_lat_reg < item_reg.latency)
                    begin
                        peak_lat_next  = item_reg.latency;
                        peak_size_next = info.size;
                    end
                    valid_next[addr] = 1'b1;
                end
            end
            OP_CMD:
            begin
                if (enable_reg && pend_valid_reg)
                begin
                    if (busy_poll)
                    begin
                        busy_time_next = item_reg.cur_time;
                    end
                    else
                    begin
                        wr_entry = 1'b1;
                        entry_new.writes    = entry_cur.writes + 1'b1;
                        entry_new.write_lat = entry_cur.write_lat + wlat_reg;
                        wtot_next = wtot_reg + CNT_W'(pend_blocks_reg);
                        if (peak_lat_reg < wlat_reg)
                        begin
                            peak_lat_next  = wlat_reg;
                            peak_size_next = entry_cur.last_size;
                        end
                        pend_valid_next  = 1'b0;
                        pend_blocks_next = '0;
                        pend_start_next  = '0;
                        valid_next[addr] = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
            end
            default:
            begin
                // clear: drop every bucket through its valid bit
                entry_new        = '0;
                valid_next       = '0;
                rtot_next        = '0;
                wtot_next        = '0;
                peak_lat_next    = '0;
                peak_size_next   = '0;
                pend_valid_next  = 1'b0;
                pend_bucket_next = '0;
                pend_blocks_next = '0;
                pend_start_next  = '0;
            end
        endcase

        out_next.bucket_index       = 3'(addr);
        out_next.bucket_chunk_bytes = entry_new.last_size;
        out_next.read_count         = entry_new.reads;
        out_next.write_count        = entry_new.writes;
        out_next.read_latency_sum   = entry_new.read_lat;
        out_next.write_latency_sum  = entry_new.write_lat;
        out_next.total_read_blocks  = rtot_next;
        out_next.total_write_blocks = wtot_next;
        out_next.max_latency        = peak_lat_next;
        out_next.max_latency_chunk  = peak_size_next;
        out_next.write_pending      = pend_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            enable_reg      <= 1'b0;
            defer_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
            out_reg         <= '0;
            valid_reg       <= '0;
            rtot_reg        <= '0;
            wtot_reg        <= '0;
            peak_lat_reg    <= '0;
            peak_size_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            pend_bucket_reg <= '0;
            pend_blocks_reg <= '0;
            pend_start_reg  <= '0;
            busy_time_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (paddr[2])
                    REG_ENABLE: enable_reg <= pwdata[0];
                    REG_DEFER:  defer_reg  <= pwdata[0];
                    default:    enable_reg <= enable_reg;
                endcase
            end

            if (m_valid_reg && m_tready && !finish)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_MODIFY;
                end
                ST_MODIFY:
                begin
                    // hold until the output register is free
                    if (finish)
                    begin
                        state_reg       <= ST_IDLE;
                        m_valid_reg     <= 1'b1;
                        out_reg         <= out_next;
                        valid_reg       <= valid_next;
                        rtot_reg        <= rtot_next;
                        wtot_reg        <= wtot_next;
                        peak_lat_reg    <= peak_lat_next;
                        peak_size_reg   <= peak_size_next;
                        pend_valid_reg  <= pend_valid_next;
                        pend_bucket_reg <= pend_bucket_next;
                        pend_blocks_reg <= pend_blocks_next;
                        pend_start_reg  <= pend_start_next;
                        busy_time_reg   <= busy_time_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tuser;
            item_reg <= item_in;
        end
        if (state_reg == ST_READ)
        begin
            // closing latency of a pending write, ready before the update cycle
            wlat_reg <= item_reg.is_send_status ? item_reg.cur_time - pend_start_reg
                                                : busy_time_reg - pend_start_reg;
        end
    end

endmodule

### dv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srlh_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1300;

    localparam logic [1:0] DIR_NONE   = 2'd0;
    localparam logic [1:0] DIR_UNUSED = 2'd3;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;
    localparam out_item_t NO_REPORT = '0;

    typedef struct packed {
        logic      en;
        logic      defer;
        logic [1:0] op;
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } plan_row_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // direction, blocks, block_size, cur_time, latency, is_send_status,
    // status_word, bucket_select (from bit 0 up)
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // op
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // bucket_index, bucket_chunk_bytes, read_count, write_count, read_latency_sum,
    // write_latency_sum, total_read_blocks, total_write_blocks, max_latency,
    // max_latency_chunk, write_pending (from bit 0 up)
    logic [OUT_DATA_W-1:0] m_tdata;

    storage_request_latency_histogram_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // histogram state as the block should hold it
    logic              cfg_enable = 1'b0;
    logic              cfg_defer  = 1'b0;
    logic [CNT_W-1:0]  st_reads     [NUM_BUCKETS];
    logic [CNT_W-1:0]  st_writes    [NUM_BUCKETS];
    logic [CNT_W-1:0]  st_rd_lat    [NUM_BUCKETS];
    logic [CNT_W-1:0]  st_wr_lat    [NUM_BUCKETS];
    logic [SIZE_W-1:0] st_last_size [NUM_BUCKETS];
    logic [CNT_W-1:0]  st_rd_blocks;
    logic [CNT_W-1:0]  st_wr_blocks;
    logic [CNT_W-1:0]  st_peak_lat;
    logic [SIZE_W-1:0] st_peak_size;
    logic              st_pend_valid;
    logic [BKT_W-1:0]  st_pend_bucket;
    logic [BLOCKS_W-1:0] st_pend_blocks;
    logic [CNT_W-1:0]  st_pend_start;
    logic [CNT_W-1:0]  st_busy_time = '0;

    out_item_t  expected_reports [$];
    plan_row_t  demo_plan [$];
    int         mismatches  = 0;
    int         cycle_count = 0;
    bit         flow_steady = 1'b0;
    logic [CNT_W-1:0] card_clock = 64'd1000;

    function automatic void clear_stats();
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            st_reads[i]     = '0;
            st_writes[i]    = '0;
            st_rd_lat[i]    = '0;
            st_wr_lat[i]    = '0;
            st_last_size[i] = '0;
        end
        st_rd_blocks   = '0;
        st_wr_blocks   = '0;
        st_peak_lat    = '0;
        st_peak_size   = '0;
        st_pend_valid  = 1'b0;
        st_pend_bucket = '0;
        st_pend_blocks = '0;
        st_pend_start  = '0;
    endfunction

    // log2 bucket relative to the smallest chunk; round non-powers of two up
    function automatic logic [BKT_W-1:0] size_bucket(input logic [PROD_W-1:0] bytes);
        int msb;
        int idx;
        msb = 0;
        for (int i = 0; i < PROD_W; i++)
            if (bytes[i])
                msb = i + 1;
        idx = msb - ($clog2(MIN_CHUNK_BYTES) + 1);
        if (bytes != '0 && (bytes & (bytes - 1'b1)) != '0)
            idx++;
        if (idx > NUM_BUCKETS - 1)
            idx = NUM_BUCKETS - 1;
        if (idx < 0)
            idx = 0;
        return idx[BKT_W-1:0];
    endfunction

    function automatic void note_peak(input logic [SIZE_W-1:0] sz, input logic [CNT_W-1:0] lat);
        if (st_peak_lat < lat)
        begin
            st_peak_lat  = lat;
            st_peak_size = sz;
        end
    endfunction

    function automatic out_item_t histogram_step(input logic [1:0] op, input in_item_t it);
        out_item_t           r;
        logic [PROD_W-1:0]   bytes;
        logic [BKT_W-1:0]    b;
        logic [CNT_W-1:0]    wlat;
        logic                busy;
        bytes = it.blocks * it.block_size;
        b     = '0;
        case (op)
            OP_DATA:
            begin
                b = size_bucket(bytes);
                if (cfg_enable)
                begin
                    if (it.direction == DIR_WRITE && cfg_defer)
                    begin
                        st_pend_valid  = 1'b1;
                        st_pend_bucket = b;
                        st_pend_blocks = it.blocks;
                        st_pend_start  = it.cur_time - it.latency;
                    end
                    else if (it.direction == DIR_WRITE)
                    begin
                        st_writes[b]++;
                        st_wr_blocks += it.blocks;
                        st_wr_lat[b] += it.latency;
                    end
                    else if (it.direction == DIR_READ)
                    begin
                        st_reads[b]++;
                        st_rd_lat[b] += it.latency;
                        st_rd_blocks += it.blocks;
                    end
                    st_last_size[b] = bytes[SIZE_W-1:0];
                    note_peak(st_last_size[b], it.latency);
                end
            end
            OP_CMD:
            begin
                b = st_pend_bucket;
                if (cfg_enable && st_pend_valid)
                begin
                    busy = !it.status_word[STAT_READY_BIT] ||
                           it.status_word[STAT_READY_BIT+4 -: 4] == CARD_STATE_PRG;
                    if (it.is_send_status && busy)
                        st_busy_time = it.cur_time;
                    else
                    begin
                        // a non-poll command closes the write at the last busy poll
                        wlat = it.is_send_status ? it.cur_time - st_pend_start
                                                 : st_busy_time - st_pend_start;
                        st_writes[b]++;
                        st_wr_blocks += st_pend_blocks;
                        st_wr_lat[b] += wlat;
                        note_peak(st_last_size[b], wlat);
                        st_pend_valid  = 1'b0;
                        st_pend_blocks = '0;
                        st_pend_start  = '0;
                    end
                end
            end
            OP_READ:
                b = it.bucket_select;
            default:
            begin
                clear_stats();
                b = it.bucket_select;
            end
        endcase
        r.bucket_index       = b;
        r.bucket_chunk_bytes = st_last_size[b];
        r.read_count         = st_reads[b];
        r.write_count        = st_writes[b];
        r.read_latency_sum   = st_rd_lat[b];
        r.write_latency_sum  = st_wr_lat[b];
        r.total_read_blocks  = st_rd_blocks;
        r.total_write_blocks = st_wr_blocks;
        r.max_latency        = st_peak_lat;
        r.max_latency_chunk  = st_peak_size;
        r.write_pending      = st_pend_valid;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int       r;
        r = $urandom_range(0, 99);
        it.direction = (r < 40) ? DIR_READ : (r < 80) ? DIR_WRITE : 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 45)
            it.blocks = 16'($urandom_range(1, 16));
        else if (r < 65)
            it.blocks = 16'd1 << $urandom_range(0, 15);
        else if (r < 90)
            it.blocks = 16'($urandom_range(0, 65535));
        else
            it.blocks = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        r = $urandom_range(0, 9);
        if (r < 7)
            it.block_size = 13'd512 << $urandom_range(0, 3);
        else if (r < 9)
            it.block_size = 13'($urandom_range(0, 4096));
        else
            it.block_size = 13'($urandom_range(0, 8191));
        if ($urandom_range(0, 99) < 95)
            card_clock += 64'($urandom_range(1, 5000));
        else
            card_clock = {$urandom, $urandom};
        it.cur_time = card_clock;
        if ($urandom_range(0, 99) < 85)
            it.latency = 64'($urandom_range(0, 100000));
        else
            it.latency = {$urandom, $urandom};
        it.is_send_status = 1'($urandom_range(0, 1));
        it.status_word    = $urandom;
        it.bucket_select  = 3'($urandom_range(0, 7));
        return it;
    endfunction

    // force a poll response to read ready, or busy (not ready or programming)
    function automatic logic [31:0] poll_status(input bit ready, input logic [31:0] base);
        logic [31:0] w;
        logic [3:0]  state;
        w     = base;
        state = w[STAT_READY_BIT+4 -: 4];
        if (ready)
        begin
            w[STAT_READY_BIT] = 1'b1;
            if (state == CARD_STATE_PRG)
                state = state + 1'b1;
        end
        else if ($urandom_range(0, 1))
            w[STAT_READY_BIT] = 1'b0;
        else
        begin
            w[STAT_READY_BIT] = 1'b1;
            state = CARD_STATE_PRG;
        end
        w[STAT_READY_BIT+4 -: 4] = state;
        return w;
    endfunction

    function automatic plan_row_t plan_row(
        input logic en, input logic defer, input logic [1:0] op, input logic [1:0] dir,
        input logic [BLOCKS_W-1:0] blocks, input logic [BSIZE_W-1:0] bsz,
        input logic [CNT_W-1:0] now, input logic [CNT_W-1:0] lat, input logic poll,
        input logic [31:0] status, input logic [2:0] sel, input bit typed,
        input out_item_t want);
        plan_row_t row;
        row.en                  = en;
        row.defer               = defer;
        row.op                  = op;
        row.item.direction      = dir;
        row.item.blocks         = blocks;
        row.item.block_size     = bsz;
        row.item.cur_time       = now;
        row.item.latency        = lat;
        row.item.is_send_status = poll;
        row.item.status_word    = status;
        row.item.bucket_select  = sel;
        row.typed               = typed;
        row.want                = want;
        return row;
    endfunction

    task automatic apb_write(input logic idx, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_ENABLE)
            cfg_enable = value;
        else
            cfg_defer = value;
    endtask

    // drain the block, then rewrite both registers
    task automatic apply_config(input logic en, input logic defer);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        apb_write(REG_ENABLE, en);
        apb_write(REG_DEFER, defer);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(input logic [1:0] op, input in_item_t it, input bit typed,
                             input out_item_t want);
        int        gap;
        out_item_t pred;
        gap = flow_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'(it);
        do
            @(posedge clk);
        while (!s_tready);
        pred = histogram_step(op, it);
        expected_reports.push_back(typed ? want : pred);
    endtask

    // result side: random stalls, compare each transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        out_item_t got;
        out_item_t want;
        int        stall_left;
        if (m_tvalid && m_tready)
        begin
            got = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
            if (expected_reports.size() == 0)
            begin
                $error("result with no expectation waiting, bucket_index %0d", got.bucket_index);
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.bucket_index !== want.bucket_index)
                    $error("bucket_index: expected %0h, got %0h", want.bucket_index, got.bucket_index);
                if (got.bucket_chunk_bytes !== want.bucket_chunk_bytes)
                    $error("bucket_chunk_bytes: expected %0h, got %0h",
                           want.bucket_chunk_bytes, got.bucket_chunk_bytes);
                if (got.read_count !== want.read_count)
                    $error("read_count: expected %0h, got %0h", want.read_count, got.read_count);
                if (got.write_count !== want.write_count)
                    $error("write_count: expected %0h, got %0h", want.write_count, got.write_count);
                if (got.read_latency_sum !== want.read_latency_sum)
                    $error("read_latency_sum: expected %0h, got %0h",
                           want.read_latency_sum, got.read_latency_sum);
                if (got.write_latency_sum !== want.write_latency_sum)
                    $error("write_latency_sum: expected %0h, got %0h",
                           want.write_latency_sum, got.write_latency_sum);
                if (got.total_read_blocks !== want.total_read_blocks)
                    $error("total_read_blocks: expected %0h, got %0h",
                           want.total_read_blocks, got.total_read_blocks);
                if (got.total_write_blocks !== want.total_write_blocks)
                    $error("total_write_blocks: expected %0h, got %0h",
                           want.total_write_blocks, got.total_write_blocks);
                if (got.max_latency !== want.max_latency)
                    $error("max_latency: expected %0h, got %0h", want.max_latency, got.max_latency);
                if (got.max_latency_chunk !== want.max_latency_chunk)
                    $error("max_latency_chunk: expected %0h, got %0h",
                           want.max_latency_chunk, got.max_latency_chunk);
                if (got.write_pending !== want.write_pending)
                    $error("write_pending: expected %0h, got %0h",
                           want.write_pending, got.write_pending);
                if (got !== want)
                    mismatches++;
            end
        end
        if (stall_left == 0 && !flow_steady)
            stall_left = idle_len();
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        in_item_t   it;
        logic [1:0] op;
        int         r;
        int         polls;
        int         quota;
        int         done;
        int         random_count;
        int         phase;
        logic       en;
        logic       defer;

        clear_stats();
        random_count = 0;
        phase        = 0;

        // after reset, collection off: everything reports zero
        demo_plan.push_back(plan_row(1'b0, 1'b0, OP_READ, DIR_NONE, 16'd0, 13'd0, 64'd0, 64'd0,
            1'b0, 32'd0, 3'd7, TYPED, '{bucket_index: 3'd7, default: '0}));
        demo_plan.push_back(plan_row(1'b0, 1'b0, OP_DATA, DIR_READ, 16'd1, 13'd4096, 64'd50,
            64'd9, 1'b0, 32'd0, 3'd0, TYPED, '{default: '0}));
        demo_plan.push_back(plan_row(1'b0, 1'b0, OP_CMD, DIR_NONE, 16'd0, 13'd0, 64'd60, 64'd0,
            1'b1, 32'd0, 3'd0, TYPED, '{default: '0}));
        // largest request with largest latency lands in the top bucket
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_DATA, DIR_READ, 16'hFFFF, 13'd4096, '1, '1,
            1'b0, 32'd0, 3'd0, TYPED,
            '{bucket_index: 3'd7, bucket_chunk_bytes: 28'hFFFF000, read_count: 64'd1,
              read_latency_sum: {CNT_W{1'b1}}, total_read_blocks: 64'd65535,
              max_latency: {CNT_W{1'b1}}, max_latency_chunk: 28'hFFFF000, default: '0}));
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_CLEAR, DIR_NONE, 16'd0, 13'd0, 64'd0, 64'd0,
            1'b0, 32'd0, 3'd5, TYPED, '{bucket_index: 3'd5, default: '0}));
        // zero-byte write, counted at once
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_DATA, DIR_WRITE, 16'd0, 13'd4096, 64'd70,
            64'd5, 1'b0, 32'd0, 3'd0, TYPED,
            '{write_count: 64'd1, write_latency_sum: 64'd5, max_latency: 64'd5, default: '0}));
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_DATA, DIR_READ, 16'd1, 13'd4096, 64'd80,
            64'd3, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_DATA, DIR_READ, 16'd2, 13'd4096, 64'd90,
            64'd7, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_DATA, DIR_WRITE, 16'd3, 13'd512, 64'd95,
            64'd11, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_DATA, DIR_READ, 16'd3, 13'd4096, 64'd99,
            64'd13, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        // product wider than the stored size
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_DATA, DIR_READ, 16'hFFFF, 13'h1FFF, 64'd120,
            64'd17, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_DATA, DIR_NONE, 16'd4, 13'd4096, 64'd130,
            64'd100, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        // equal latency leaves the peak alone
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_DATA, DIR_UNUSED, 16'd5, 13'd4096, 64'd140,
            64'd100, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        // deferred writes: nothing pending, replace, busy polls, ready poll
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_CMD, DIR_NONE, 16'd0, 13'd0, 64'd150, 64'd0,
            1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_DATA, DIR_WRITE, 16'd8, 13'd512, 64'd1000,
            64'd100, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_DATA, DIR_WRITE, 16'd16, 13'd4096, 64'd1500,
            64'd200, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_CMD, DIR_NONE, 16'd0, 13'd0, 64'd2000, 64'd0,
            1'b1, 32'h0000_0000, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_CMD, DIR_NONE, 16'd0, 13'd0, 64'd2500, 64'd0,
            1'b1, 32'h0000_0F00, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_CMD, DIR_NONE, 16'd0, 13'd0, 64'd3000, 64'd0,
            1'b1, 32'h0000_0900, 3'd0, PREDICTED, NO_REPORT));
        // start time wraps below zero, then a plain command closes it
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_DATA, DIR_WRITE, 16'd1, 13'd1024, 64'd10,
            64'd40, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_CMD, DIR_NONE, 16'd0, 13'd0, 64'd3100, 64'd0,
            1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        // pending write survives turning deferred mode off
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_DATA, DIR_WRITE, 16'd4, 13'd4096, 64'd5000,
            64'd10, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b0, OP_CMD, DIR_NONE, 16'd0, 13'd0, 64'd6000, 64'd0,
            1'b1, 32'hFFFF_FFFF, 3'd0, PREDICTED, NO_REPORT));
        // clear drops a pending write
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_DATA, DIR_WRITE, 16'd2, 13'd2048, 64'd7000,
            64'd1, 1'b0, 32'd0, 3'd0, PREDICTED, NO_REPORT));
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_CLEAR, DIR_NONE, 16'd0, 13'd0, 64'd0, 64'd0,
            1'b0, 32'd0, 3'd0, TYPED, '{default: '0}));
        demo_plan.push_back(plan_row(1'b1, 1'b1, OP_CMD, DIR_NONE, 16'd0, 13'd0, 64'd7100, 64'd0,
            1'b0, 32'd0, 3'd0, TYPED, '{default: '0}));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (demo_plan[i])
        begin
            if (demo_plan[i].en != cfg_enable || demo_plan[i].defer != cfg_defer)
                apply_config(demo_plan[i].en, demo_plan[i].defer);
            send_item(demo_plan[i].op, demo_plan[i].item, demo_plan[i].typed, demo_plan[i].want);
        end

        while (random_count < RANDOM_ITEMS)
        begin
            case (phase)
                0: {en, defer} = 2'b11;
                1: {en, defer} = 2'b10;
                2: {en, defer} = 2'b01;
                3: {en, defer} = 2'b11;
                default:
                begin
                    en    = ($urandom_range(0, 99) < 85);
                    defer = 1'($urandom_range(0, 1));
                end
            endcase
            apply_config(en, defer);
            flow_steady = (phase % 4 == 3);
            quota = en ? $urandom_range(80, 200) : 30;
            done  = 0;
            while (done < quota)
            begin
                if (cfg_enable && cfg_defer && $urandom_range(0, 99) < 60)
                begin
                    // write, a few busy polls, then a ready poll or another command
                    it = rand_item();
                    it.direction = DIR_WRITE;
                    send_item(OP_DATA, it, PREDICTED, NO_REPORT);
                    polls = $urandom_range(0, 3);
                    repeat (polls)
                    begin
                        it = rand_item();
                        it.is_send_status = 1'b1;
                        it.status_word    = poll_status(1'b0, it.status_word);
                        send_item(OP_CMD, it, PREDICTED, NO_REPORT);
                    end
                    it = rand_item();
                    if ($urandom_range(0, 1))
                    begin
                        it.is_send_status = 1'b1;
                        it.status_word    = poll_status(1'b1, it.status_word);
                    end
                    else
                        it.is_send_status = 1'b0;
                    send_item(OP_CMD, it, PREDICTED, NO_REPORT);
                    done += polls + 2;
                end
                else
                begin
                    r  = $urandom_range(0, 99);
                    op = (r < 50) ? OP_DATA : (r < 80) ? OP_CMD : (r < 97) ? OP_READ : OP_CLEAR;
                    send_item(op, rand_item(), PREDICTED, NO_REPORT);
                    done++;
                end
            end
            if (en)
                random_count += done;
            phase++;
        end

        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
